/* rtl/core/gbb_pkg.sv */
package gbb_pkg;

    // Pixel and arithmetic widths
    localparam int PIX_W     = 8;
    localparam int CH        = 3;
    localparam int RGB_W     = CH * PIX_W;
    localparam int WT_W      = 17;
    localparam int VP_W      = WT_W + PIX_W;     // one vertical tap product
    localparam int VS_W      = VP_W + 3;         // sum of up to eight vertical taps
    localparam int PROD_W    = VS_W + WT_W;      // horizontal tap product
    localparam int SUM_W     = PROD_W + 3;       // sum of up to eight horizontal taps
    localparam int BLUR_LSB  = 32;               // Q2.32 weight product
    localparam int BLUR_W    = SUM_W - BLUR_LSB;

    // Configuration register widths
    localparam int FW_W      = 12;
    localparam int FH_W      = 13;
    localparam int BR_W      = 2;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_WT    = 4;

    // Result queue
    localparam int OUT_DEPTH = 16;
    localparam int OUT_AW    = 4;
    localparam int PEND_W    = 5;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_BLUR_RADIUS  = 3'd2,
        REG_WEIGHT_CTR   = 3'd3,
        REG_WEIGHT_ONE   = 3'd4,
        REG_WEIGHT_TWO   = 3'd5,
        REG_WEIGHT_THREE = 3'd6
    } cfg_reg_t;

    // Channel 2 is red, 1 green, 0 blue
    typedef logic [CH-1:0][PIX_W-1:0] rgb_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
        logic             is_flush;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             last_of_frame;
    } pix_out_t;

    // One window column as held by a cell
    typedef struct packed {
        logic [CH-1:0][VS_W-1:0] vsum;
        rgb_t                    orig;
    } cell_t;

    // Per-beat control carried down the pipeline
    typedef struct packed {
        logic has_res;
        logic interior;
        logic last;
    } ctrl_t;

endpackage

/* rtl/core/gbb_stream_if.sv */
interface gbb_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/gbb_ram.sv */
module gbb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* rtl/core/gbb_cell.sv */
module gbb_cell (
    input  logic                                       clk,
    input  logic                                       shift,
    input  gbb_pkg::cell_t                             din,
    input  logic [gbb_pkg::WT_W-1:0]                   weight,
    output gbb_pkg::cell_t                             dout,
    output logic [gbb_pkg::CH-1:0][gbb_pkg::PROD_W-1:0] prod
);
    gbb_pkg::cell_t                              data_reg;
    logic [gbb_pkg::CH-1:0][gbb_pkg::PROD_W-1:0] prod_reg;

    // column moves one place older on each counted beat
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= din;
        end
    end

    // horizontal tap product, refreshed every cycle
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < gbb_pkg::CH; c++)
        begin
            prod_reg[c] <= gbb_pkg::PROD_W'(data_reg.vsum[c]) *
                           gbb_pkg::PROD_W'(weight);
        end
    end

    assign dout = data_reg;
    assign prod = prod_reg;
endmodule

/* rtl/core/gaussian_blur_blend_filter_top.sv */
// Channel   Dir  Handshake       Payload
// pixels    in   valid/ready     red_in, green_in, blue_in, is_flush
// results   out  valid/ready     red_out, green_out, blue_out, last_of_frame
// cfg       in   cfg_we          cfg_index (3b), cfg_data (17b), no read-back
//
// One pixel per clock while pixels.ready is high; a result passes st1, st2,
// the cell column and product registers, st5 and a 16-entry result queue.
// The line store is one RAM of 2*MAX_RADIUS pixels per word, read and
// rewritten once per beat (with a bypass for one-pixel rows).
// Reset clears counters, valids and the queue; the line store needs no clearing.
// pixels.ready drops only while 16 results are pending in flight or queued.
module gaussian_blur_blend_filter_top #(
    parameter int MAX_RADIUS = 3,
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gbb_pkg::CFG_W-1:0]       cfg_data,
    gbb_stream_if.sink                      pixels,
    gbb_stream_if.source                    results
);
    localparam int TAPS   = 2 * MAX_RADIUS + 1;
    localparam int TAP_IW = $clog2(TAPS);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int RAM_W  = (TAPS - 1) * gbb_pkg::RGB_W;
    localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                   + MAX_RADIUS + 1);
    localparam logic [gbb_pkg::FW_W:0] MAXW = (gbb_pkg::FW_W + 1)'(MAX_WIDTH);
    localparam logic [gbb_pkg::FH_W:0] MAXH = (gbb_pkg::FH_W + 1)'(MAX_HEIGHT);

    // configuration registers
    logic [gbb_pkg::FW_W-1:0] fw_reg;
    logic [gbb_pkg::FH_W-1:0] fh_reg;
    logic [gbb_pkg::BR_W-1:0] br_reg;
    logic [gbb_pkg::WT_W-1:0] wt_reg [gbb_pkg::NUM_WT];

    // frame counters
    logic [CNT_W-1:0]         in_cnt_reg;
    logic [COL_W-1:0]         x_in_reg;
    logic [gbb_pkg::FW_W-1:0] x_out_reg;
    logic [gbb_pkg::FH_W-1:0] y_out_reg;

    // effective frame settings
    logic [gbb_pkg::FW_W-1:0]             w_eff;
    logic [gbb_pkg::FH_W-1:0]             h_eff;
    logic [gbb_pkg::BR_W-1:0]             r_eff;
    logic [gbb_pkg::FW_W+gbb_pkg::FH_W-1:0] total_full;
    logic [CNT_W-1:0]                     total;
    logic [CNT_W-1:0]                     delay;
    logic [CNT_W-1:0]                     lim;
    logic [gbb_pkg::WT_W-1:0]             wv [TAPS];

    // beat decision
    logic           accept;
    logic           counted;
    logic           has_res;
    logic           last_px;
    logic           frame_done;
    logic           interior;
    logic           cfg_hit;
    gbb_pkg::rgb_t  in_pix;

    // line store
    logic [RAM_W-1:0] ram_q;
    logic [RAM_W-1:0] word;
    logic [RAM_W-1:0] wr_word;
    logic             fwd_reg;
    logic [RAM_W-1:0] fwd_data_reg;

    // pipeline
    logic                 st1_v_reg;
    gbb_pkg::rgb_t        st1_pix_reg;
    gbb_pkg::ctrl_t       st1_ctrl_reg;
    logic [COL_W-1:0]     st1_addr_reg;
    gbb_pkg::rgb_t        col [TAPS];

    logic                 st2_v_reg;
    gbb_pkg::ctrl_t       st2_ctrl_reg;
    gbb_pkg::rgb_t        st2_orig_reg;
    logic [gbb_pkg::CH-1:0][gbb_pkg::VP_W-1:0] st2_vp_reg [TAPS];
    gbb_pkg::cell_t       cell_in;

    gbb_pkg::cell_t       cell_q [TAPS];
    logic [gbb_pkg::CH-1:0][gbb_pkg::PROD_W-1:0] cell_prod [TAPS];

    logic                 st3_v_reg;
    gbb_pkg::ctrl_t       st3_ctrl_reg;
    logic                 st4_v_reg;
    gbb_pkg::ctrl_t       st4_ctrl_reg;
    gbb_pkg::rgb_t        st4_orig_reg;
    logic                 st5_v_reg;
    gbb_pkg::ctrl_t       st5_ctrl_reg;
    gbb_pkg::rgb_t        st5_orig_reg;
    logic [gbb_pkg::CH-1:0][gbb_pkg::SUM_W-1:0] st5_sa_reg;
    logic [gbb_pkg::CH-1:0][gbb_pkg::SUM_W-1:0] st5_sb_reg;
    logic [gbb_pkg::CH-1:0][gbb_pkg::SUM_W-1:0] sa_next;
    logic [gbb_pkg::CH-1:0][gbb_pkg::SUM_W-1:0] sb_next;
    gbb_pkg::rgb_t        res_pix;

    // result queue
    gbb_pkg::pix_out_t            q_mem [gbb_pkg::OUT_DEPTH];
    logic [gbb_pkg::OUT_AW-1:0]   q_wp_reg;
    logic [gbb_pkg::OUT_AW-1:0]   q_rp_reg;
    logic [gbb_pkg::PEND_W-1:0]   q_cnt_reg;
    logic [gbb_pkg::PEND_W-1:0]   pend_reg;
    logic                         out_hs;

    // effective settings from the registers
    always_comb
    begin
        if (fw_reg == '0)
            w_eff = gbb_pkg::FW_W'(1);
        else if ({1'b0, fw_reg} > MAXW)
            w_eff = MAXW[gbb_pkg::FW_W-1:0];
        else
            w_eff = fw_reg;
        if (fh_reg == '0)
            h_eff = gbb_pkg::FH_W'(1);
        else if ({1'b0, fh_reg} > MAXH)
            h_eff = MAXH[gbb_pkg::FH_W-1:0];
        else
            h_eff = fh_reg;
        if (br_reg > gbb_pkg::BR_W'(MAX_RADIUS))
            r_eff = gbb_pkg::BR_W'(MAX_RADIUS);
        else
            r_eff = br_reg;
    end

    assign total_full = w_eff * h_eff;
    assign total      = CNT_W'(total_full);
    assign delay      = (CNT_W'(r_eff) * CNT_W'(w_eff)) + CNT_W'(r_eff);
    assign lim        = total + delay;

    // tap weights: offset |k - r| inside the window, zero outside
    always_comb
    begin
        int d;
        d = 0;
        for (int k = 0; k < TAPS; k++)
        begin
            d = (k > int'(r_eff)) ? k - int'(r_eff) : int'(r_eff) - k;
            if (k <= 2 * int'(r_eff))
                wv[k] = wt_reg[2'(d)];
            else
                wv[k] = '0;
        end
    end

    // beat decision
    assign accept     = pixels.valid && pixels.ready;
    assign counted    = (in_cnt_reg < total) ? !pixels.data.is_flush : (in_cnt_reg < lim);
    assign has_res    = counted && (in_cnt_reg >= delay);
    assign last_px    = (x_out_reg == w_eff - 1'b1) && (y_out_reg == h_eff - 1'b1);
    assign frame_done = has_res && last_px;
    assign interior   = (x_out_reg >= gbb_pkg::FW_W'(r_eff)) &&
                        ((13'(x_out_reg) + 13'(r_eff)) < 13'(w_eff)) &&
                        (y_out_reg >= gbb_pkg::FH_W'(r_eff)) &&
                        ((14'(y_out_reg) + 14'(r_eff)) < 14'(h_eff));
    assign in_pix     = {pixels.data.red_in, pixels.data.green_in, pixels.data.blue_in};
    assign pixels.ready = pend_reg < gbb_pkg::PEND_W'(gbb_pkg::OUT_DEPTH);

    always_comb
    begin
        unique case (cfg_index)
            gbb_pkg::REG_FRAME_WIDTH,
            gbb_pkg::REG_FRAME_HEIGHT,
            gbb_pkg::REG_BLUR_RADIUS,
            gbb_pkg::REG_WEIGHT_CTR,
            gbb_pkg::REG_WEIGHT_ONE,
            gbb_pkg::REG_WEIGHT_TWO,
            gbb_pkg::REG_WEIGHT_THREE: cfg_hit = cfg_we;
            default:                   cfg_hit = 1'b0;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg    <= gbb_pkg::FW_W'(640);
            fh_reg    <= gbb_pkg::FH_W'(480);
            br_reg    <= '0;
            wt_reg[0] <= gbb_pkg::WT_W'(65536);
            wt_reg[1] <= '0;
            wt_reg[2] <= '0;
            wt_reg[3] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gbb_pkg::REG_FRAME_WIDTH:  fw_reg    <= cfg_data[gbb_pkg::FW_W-1:0];
                gbb_pkg::REG_FRAME_HEIGHT: fh_reg    <= cfg_data[gbb_pkg::FH_W-1:0];
                gbb_pkg::REG_BLUR_RADIUS:  br_reg    <= cfg_data[gbb_pkg::BR_W-1:0];
                gbb_pkg::REG_WEIGHT_CTR:   wt_reg[0] <= cfg_data;
                gbb_pkg::REG_WEIGHT_ONE:   wt_reg[1] <= cfg_data;
                gbb_pkg::REG_WEIGHT_TWO:   wt_reg[2] <= cfg_data;
                gbb_pkg::REG_WEIGHT_THREE: wt_reg[3] <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // frame counters: a write to any of the seven registers aborts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg <= '0;
            x_in_reg   <= '0;
            x_out_reg  <= '0;
            y_out_reg  <= '0;
        end
        else if (cfg_hit)
        begin
            in_cnt_reg <= '0;
            x_in_reg   <= '0;
            x_out_reg  <= '0;
            y_out_reg  <= '0;
        end
        else if (accept && counted)
        begin
            if (frame_done)
            begin
                in_cnt_reg <= '0;
                x_in_reg   <= '0;
                x_out_reg  <= '0;
                y_out_reg  <= '0;
            end
            else
            begin
                in_cnt_reg <= in_cnt_reg + 1'b1;
                if (gbb_pkg::FW_W'(x_in_reg) == w_eff - 1'b1)
                    x_in_reg <= '0;
                else
                    x_in_reg <= x_in_reg + 1'b1;
                if (has_res)
                begin
                    if (x_out_reg == w_eff - 1'b1)
                    begin
                        x_out_reg <= '0;
                        y_out_reg <= y_out_reg + 1'b1;
                    end
                    else
                    begin
                        x_out_reg <= x_out_reg + 1'b1;
                    end
                end
            end
        end
    end

    // line store: word slot i holds the pixel i+1 rows above
    gbb_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (st1_v_reg),
        .waddr (st1_addr_reg),
        .wdata (wr_word),
        .re    (accept),
        .raddr (x_in_reg),
        .rdata (ram_q)
    );

    // column assembly and rewrite shifted down by one row
    always_comb
    begin
        word   = fwd_reg ? fwd_data_reg : ram_q;
        col[0] = st1_pix_reg;
        for (int k = 1; k < TAPS; k++)
        begin
            col[k] = word[(k - 1) * gbb_pkg::RGB_W +: gbb_pkg::RGB_W];
        end
        for (int i = 0; i < TAPS - 1; i++)
        begin
            wr_word[i * gbb_pkg::RGB_W +: gbb_pkg::RGB_W] = col[i];
        end
    end

    // vertical sum entering the first cell
    always_comb
    begin
        for (int c = 0; c < gbb_pkg::CH; c++)
        begin
            cell_in.vsum[c] = '0;
            for (int k = 0; k < TAPS; k++)
            begin
                cell_in.vsum[c] = cell_in.vsum[c] + gbb_pkg::VS_W'(st2_vp_reg[k][c]);
            end
        end
        cell_in.orig = st2_orig_reg;
    end

    // row of window cells, newest column in cell 0
    for (genvar j = 0; j < TAPS; j++)
    begin : g_cell
        gbb_cell u_cell (
            .clk    (clk),
            .shift  (st2_v_reg),
            .din    ((j == 0) ? cell_in : cell_q[(j == 0) ? 0 : j - 1]),
            .weight (wv[j]),
            .dout   (cell_q[j]),
            .prod   (cell_prod[j])
        );
    end

    // split horizontal sum
    always_comb
    begin
        for (int c = 0; c < gbb_pkg::CH; c++)
        begin
            sa_next[c] = '0;
            sb_next[c] = '0;
            for (int j = 0; j < TAPS; j++)
            begin
                if (j < TAPS / 2)
                    sa_next[c] = sa_next[c] + gbb_pkg::SUM_W'(cell_prod[j][c]);
                else
                    sb_next[c] = sb_next[c] + gbb_pkg::SUM_W'(cell_prod[j][c]);
            end
        end
    end

    // final sum, clamp, blend with the center, edge pass-through
    always_comb
    begin
        logic [gbb_pkg::SUM_W-1:0]  tot;
        logic [gbb_pkg::BLUR_W-1:0] blur;
        logic [gbb_pkg::PIX_W-1:0]  b8;
        logic [gbb_pkg::PIX_W:0]    mix;
        tot  = '0;
        blur = '0;
        b8   = '0;
        mix  = '0;
        for (int c = 0; c < gbb_pkg::CH; c++)
        begin
            tot  = st5_sa_reg[c] + st5_sb_reg[c];
            blur = tot[gbb_pkg::SUM_W-1:gbb_pkg::BLUR_LSB];
            b8   = (blur > gbb_pkg::BLUR_W'(255)) ? '1 : blur[gbb_pkg::PIX_W-1:0];
            mix  = {1'b0, b8} + {1'b0, st5_orig_reg[c]};
            res_pix[c] = st5_ctrl_reg.interior ? mix[gbb_pkg::PIX_W:1] : st5_orig_reg[c];
        end
    end

    // pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_v_reg <= 1'b0;
            st2_v_reg <= 1'b0;
            st3_v_reg <= 1'b0;
            st4_v_reg <= 1'b0;
            st5_v_reg <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            st1_v_reg <= accept && counted;
            st2_v_reg <= st1_v_reg;
            st3_v_reg <= st2_v_reg && st2_ctrl_reg.has_res;
            st4_v_reg <= st3_v_reg;
            st5_v_reg <= st4_v_reg;
            if (accept)
                fwd_reg <= st1_v_reg && (st1_addr_reg == x_in_reg);
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fwd_data_reg          <= wr_word;
            st1_pix_reg           <= in_pix;
            st1_addr_reg          <= x_in_reg;
            st1_ctrl_reg.has_res  <= has_res;
            st1_ctrl_reg.interior <= interior;
            st1_ctrl_reg.last     <= last_px;
        end
        for (int k = 0; k < TAPS; k++)
        begin
            for (int c = 0; c < gbb_pkg::CH; c++)
            begin
                st2_vp_reg[k][c] <= gbb_pkg::VP_W'(wv[k]) * gbb_pkg::VP_W'(col[k][c]);
            end
        end
        st2_orig_reg <= col[TAP_IW'(r_eff)];
        st2_ctrl_reg <= st1_ctrl_reg;
        st3_ctrl_reg <= st2_ctrl_reg;
        st4_ctrl_reg <= st3_ctrl_reg;
        st4_orig_reg <= cell_q[TAP_IW'(r_eff)].orig;
        st5_ctrl_reg <= st4_ctrl_reg;
        st5_orig_reg <= st4_orig_reg;
        st5_sa_reg   <= sa_next;
        st5_sb_reg   <= sb_next;
    end

    // result queue and pending count
    assign out_hs        = results.valid && results.ready;
    assign results.valid = q_cnt_reg != '0;
    assign results.data  = q_mem[q_rp_reg];

    always_ff @(posedge clk)
    begin
        if (st5_v_reg)
        begin
            q_mem[q_wp_reg].red_out       <= res_pix[2];
            q_mem[q_wp_reg].green_out     <= res_pix[1];
            q_mem[q_wp_reg].blue_out      <= res_pix[0];
            q_mem[q_wp_reg].last_of_frame <= st5_ctrl_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg  <= '0;
            q_rp_reg  <= '0;
            q_cnt_reg <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            if (st5_v_reg)
                q_wp_reg <= q_wp_reg + 1'b1;
            if (out_hs)
                q_rp_reg <= q_rp_reg + 1'b1;
            q_cnt_reg <= q_cnt_reg + gbb_pkg::PEND_W'(st5_v_reg)
                                   - gbb_pkg::PEND_W'(out_hs);
            pend_reg  <= pend_reg + gbb_pkg::PEND_W'(accept && has_res)
                                  - gbb_pkg::PEND_W'(out_hs);
        end
    end
endmodule
